>>> rtl/core/prtp_pkg.sv
// Package for the point record text parser: widths, character codes and the
// shared state and write-request types. No dependencies.
`timescale 1ns / 1ps

package prtp_pkg;

  localparam int VALUE_WIDTH     = 24;
  localparam int FIELDS_PER_LINE = 6;
  localparam int NUM_SLOTS       = 6;
  localparam int OUT_WIDTH       = 24;
  localparam int CNT_WIDTH       = $clog2(FIELDS_PER_LINE + 2);
  localparam int SLOT_WIDTH      = $clog2(NUM_SLOTS);

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [OUT_WIDTH-1:0]   out_value_t;

  typedef struct packed {
    value_t               acc;
    logic                 pending;
    logic [CNT_WIDTH-1:0] cnt;
  } prtp_state_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_WIDTH-1:0] idx;
  } prtp_wr_t;

  // Zero-extends or truncates a field value to the result width.
  function automatic out_value_t to_out(input value_t v);
    logic [VALUE_WIDTH+OUT_WIDTH-1:0] wide;
    wide = {{OUT_WIDTH{1'b0}}, v};
    return wide[OUT_WIDTH-1:0];
  endfunction

endpackage

>>> rtl/core/prtp_byte_if.sv
// Valid/ready channel carrying one text byte per transaction.
// No dependencies.
`timescale 1ns / 1ps

interface prtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

>>> rtl/core/prtp_rec_if.sv
// Valid/ready channel carrying one parsed point record per transaction.
// Depends on prtp_pkg for the field width.
`timescale 1ns / 1ps

interface prtp_rec_if;
  import prtp_pkg::*;

  logic       valid;
  logic       ready;
  out_value_t coord_x;
  out_value_t coord_y;
  out_value_t coord_z;
  out_value_t color_red;
  out_value_t color_green;
  out_value_t color_blue;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output color_red, output color_green, output color_blue,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input color_red, input color_green, input color_blue,
                  output ready);
endinterface

>>> rtl/core/point_record_text_parser_core.sv
// Top level of the point record text parser: input byte register, per-byte
// state update, field store and record output register.
// Depends on prtp_pkg, prtp_byte_if, prtp_rec_if and prtp_line_step.
`timescale 1ns / 1ps

// Usage
// The chars channel takes one byte of "x y z r g b" text per transaction.
// Digits build a decimal value that saturates at the all-ones field value.
// A space closes a pending value into the next field slot; a newline closes
// any pending value and, when the line held exactly six fields, produces one
// transaction on the records channel carrying the six raw field values.
// Tabs, dots, minus signs, CR and every other byte are ignored, and a last
// line without a newline never produces a record.
// A byte is first held in the input register and then processed; a record
// is loaded into the record output register, which drives records.
// Throughput: one byte per cycle. The record output register lets parsing
// continue while a record waits; only a newline that would produce a second
// record stalls (chars.ready falls) until the waiting record is taken.
// Reset (rst, synchronous, active high) empties both registers and clears the
// accumulator and field count; the field store holds no reset value because
// a record only reads slots written on its own line.
module point_record_text_parser_core (
  input  logic              clk,
  input  logic              rst,
  prtp_byte_if.sink         chars,
  prtp_rec_if.source        records
);
  import prtp_pkg::*;

  // Input register.
  logic       byte_valid;
  logic [7:0] byte_q;

  // Parser state and field store.
  prtp_state_t state;
  prtp_state_t state_next;
  prtp_wr_t    wr;
  logic        emit;
  value_t      store [NUM_SLOTS];

  // Record output register.
  logic       out_valid;
  out_value_t rec_q    [NUM_SLOTS];
  out_value_t rec_next [NUM_SLOTS];

  logic advance;

  prtp_line_step u_step (
    .char_byte  (byte_q),
    .state      (state),
    .state_next (state_next),
    .wr         (wr),
    .emit       (emit)
  );

  // A registered byte moves on unless it would produce a record while the
  // output register still holds one that has not been taken.
  assign advance     = byte_valid && (!emit || !out_valid || records.ready);
  assign chars.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      byte_q <= chars.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr.en) begin
      store[wr.idx] <= state.acc;
    end
  end

  // The newline may close the last field in the same cycle, so that slot is
  // taken straight from the accumulator.
  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (j < FIELDS_PER_LINE) begin
        if (wr.en && (wr.idx == SLOT_WIDTH'(j))) begin
          rec_next[j] = to_out(state.acc);
        end else begin
          rec_next[j] = to_out(store[j]);
        end
      end else begin
        rec_next[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (records.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      rec_q <= rec_next;
    end
  end

  assign records.valid       = out_valid;
  assign records.coord_x     = rec_q[0];
  assign records.coord_y     = rec_q[1];
  assign records.coord_z     = rec_q[2];
  assign records.color_red   = rec_q[3];
  assign records.color_green = rec_q[4];
  assign records.color_blue  = rec_q[5];

endmodule

>>> rtl/core/prtp_line_step.sv
// Combinational per-byte update of the line parser state: digit accumulation
// with saturation, field closing and record detection. Depends on prtp_pkg.
`timescale 1ns / 1ps

module prtp_line_step (
  input  logic [7:0]            char_byte,
  input  prtp_pkg::prtp_state_t state,
  output prtp_pkg::prtp_state_t state_next,
  output prtp_pkg::prtp_wr_t    wr,
  output logic                  emit
);
  import prtp_pkg::*;

  logic                   is_digit;
  logic                   is_space;
  logic                   is_newline;
  logic [7:0]             digit_full;
  logic [VALUE_WIDTH+3:0] prod;
  logic                   sat;
  logic                   close;
  logic [CNT_WIDTH-1:0]   cnt_closed;

  assign is_digit   = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
  assign is_space   = (char_byte == CHAR_SPACE);
  assign is_newline = (char_byte == CHAR_NEWLINE);
  assign digit_full = char_byte - CHAR_ZERO;

  // acc * 10 + d as two shifted adds; overflow past the value range saturates.
  assign prod = {1'b0, state.acc, 3'b000} + {3'b000, state.acc, 1'b0}
              + {{VALUE_WIDTH{1'b0}}, digit_full[3:0]};
  assign sat  = (prod > {4'b0000, VALUE_MAX});

  assign close = (is_space || is_newline) && state.pending;

  always_comb begin
    cnt_closed = state.cnt;
    if (close && (state.cnt < CNT_WIDTH'(FIELDS_PER_LINE + 1))) begin
      cnt_closed = state.cnt + CNT_WIDTH'(1);
    end
  end

  assign wr.en  = close && (state.cnt < CNT_WIDTH'(FIELDS_PER_LINE));
  assign wr.idx = SLOT_WIDTH'(state.cnt);
  assign emit   = is_newline && (cnt_closed == CNT_WIDTH'(FIELDS_PER_LINE));

  always_comb begin
    state_next = state;
    if (is_digit) begin
      state_next.acc     = sat ? VALUE_MAX : prod[VALUE_WIDTH-1:0];
      state_next.pending = 1'b1;
    end else if (is_newline) begin
      state_next.acc     = '0;
      state_next.pending = 1'b0;
      state_next.cnt     = '0;
    end else if (close) begin
      state_next.acc     = '0;
      state_next.pending = 1'b0;
      state_next.cnt     = cnt_closed;
    end
  end

endmodule

>>> bench/point_record_text_parser_core_test.sv
// Self-checking testbench for point_record_text_parser_core: drives text bytes,
// predicts parsed point records and checks every record transaction.
// Depends on prtp_pkg, prtp_byte_if, prtp_rec_if and the core itself.
`timescale 1ns / 1ps

module point_record_text_parser_core_test;
  import prtp_pkg::*;

  // Characters that the parser must skip without touching its line state.
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam int N_ROWS         = 6;
  localparam int RANDOM_BYTES   = 1800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  // One parsed line as it leaves the records channel.
  typedef struct packed {
    out_value_t coord_x;
    out_value_t coord_y;
    out_value_t coord_z;
    out_value_t color_red;
    out_value_t color_green;
    out_value_t color_blue;
  } point_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  prtp_byte_if chars_ch();
  prtp_rec_if  records_ch();

  point_record_text_parser_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_ch),
    .records (records_ch)
  );

  always #6 clk = ~clk;

  // Records that the parser owes us, oldest first.
  point_rec_t expected_points[$];
  int         error_count;
  int         idle_cycles;

  // Our own copy of the line state: the number being built, whether any digit
  // has arrived since the last separator, how many fields the line holds so
  // far and the values of the fields already closed.
  value_t                acc_value;
  logic                  acc_valid;
  logic [CNT_WIDTH-1:0]  field_count;
  value_t                slot_value [NUM_SLOTS];

  // Random idling controls for the two sides; each is switched on and off in
  // stretches so that some phases of the run see no idling at all.
  bit gaps_on;
  bit stalls_on;
  int stall_left;

  // Directed text lines. Each one ends in a newline, so any record it causes
  // is due right after its last byte is accepted.
  string      row_text    [N_ROWS];
  bit         row_typed   [N_ROWS];
  bit         row_has_rec [N_ROWS];
  point_rec_t row_rec     [N_ROWS];

  logic [7:0] text_line [$];
  logic [7:0] junk_chars [4] = '{CHAR_TAB, CHAR_CR, CHAR_MINUS, CHAR_DOT};

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input out_value_t got, input out_value_t want);
    if (got !== want) begin
      flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic void clear_line_state();
    acc_value   = '0;
    acc_valid   = 1'b0;
    field_count = '0;
  endfunction

  // A space or newline ends a field only if a digit came since the last one.
  // Fields past the sixth are counted once more and then the count sticks,
  // which is enough to keep such a line from producing a record.
  function automatic void close_field();
    if (!acc_valid) begin
      return;
    end
    if (field_count < FIELDS_PER_LINE) begin
      slot_value[field_count] = acc_value;
    end
    if (field_count < FIELDS_PER_LINE + 1) begin
      field_count = field_count + 1'b1;
    end
    acc_value = '0;
    acc_valid = 1'b0;
  endfunction

  // Advances the predicted line state by one byte and reports whether that
  // byte completes a record, and if so which one.
  task automatic parse_char(input logic [7:0] ch, output bit made, output point_rec_t rec);
    value_t     digit;
    out_value_t vals [NUM_SLOTS];
    made = 1'b0;
    rec  = '0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      digit = value_t'(ch - CHAR_ZERO);
      // Saturate instead of wrapping once ten times the value plus the new
      // digit no longer fits.
      if (acc_value > (VALUE_MAX - digit) / 10) begin
        acc_value = VALUE_MAX;
      end else begin
        acc_value = value_t'(acc_value * 10 + digit);
      end
      acc_valid = 1'b1;
    end else if (ch == CHAR_SPACE) begin
      close_field();
    end else if (ch == CHAR_NEWLINE) begin
      close_field();
      if (field_count == FIELDS_PER_LINE) begin
        made = 1'b1;
        for (int j = 0; j < NUM_SLOTS; j++) begin
          vals[j] = (j < FIELDS_PER_LINE) ? out_value_t'(slot_value[j]) : '0;
        end
        rec = '{vals[0], vals[1], vals[2], vals[3], vals[4], vals[5]};
      end
      clear_line_state();
    end
  endtask

  // Offers one byte on the chars channel, after an optional idle gap, and
  // returns at the edge where the transaction is accepted. Valid stays high
  // when the next byte follows without a gap.
  task automatic push_char(input logic [7:0] ch, output bit made, output point_rec_t rec);
    int gap;
    int pick;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 98) begin
        gap = $urandom_range(20, 60);
      end else if (pick >= 90) begin
        gap = $urandom_range(4, 8);
      end else if (pick >= 60) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      chars_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_ch.valid     <= 1'b1;
    chars_ch.char_byte <= ch;
    do @(posedge clk); while (!chars_ch.ready);
    parse_char(ch, made, rec);
  endtask

  // Appends one byte to the line being built.
  function automatic void add_char(input logic [7:0] ch);
    text_line = {text_line, ch};
  endfunction

  // Builds one random line into text_line. Most lines are well formed with
  // six fields of random digits, now and then padded with extra spaces and
  // bytes that the parser skips. The rest have the wrong number of fields or
  // are plain noise over the whole byte range.
  task automatic compose_line();
    int kind;
    int nfields;
    int ndigits;
    text_line.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) begin
        add_char(CHAR_NEWLINE);
      end
      return;
    end
    nfields = (kind < 75) ? FIELDS_PER_LINE : $urandom_range(0, FIELDS_PER_LINE + 3);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) add_char(CHAR_SPACE);
    end
    for (int f = 0; f < nfields; f++) begin
      // Mostly short numbers; about one field in ten is longer, long enough at
      // eight or more digits to reach or pass the saturation point.
      ndigits = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 3);
      for (int k = 0; k < ndigits; k++) begin
        add_char(8'(CHAR_ZERO + 8'($urandom_range(0, 9))));
        if ($urandom_range(0, 19) == 0) begin
          add_char(junk_chars[$urandom_range(0, 3)]);
        end
      end
      if ($urandom_range(0, 39) == 0) begin
        add_char(8'($urandom_range(0, 255)));
      end
      if (f < nfields - 1) begin
        add_char(CHAR_SPACE);
        if ($urandom_range(0, 7) == 0) begin
          add_char(CHAR_SPACE);
        end
      end else if ($urandom_range(0, 4) == 0) begin
        add_char(CHAR_SPACE);
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      add_char(CHAR_CR);
    end
    add_char(CHAR_NEWLINE);
  endtask

  // Records sink: ready is mostly high, with short stalls and now and then a
  // long one, and whole stretches where it never drops.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      stalls_on  = 1'b1;
      records_ch.ready <= 1'b1;
    end else begin
      if (stall_left == 0 && stalls_on) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            stall_left = $urandom_range(1, 3);
          end
          4: begin
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
          end
          default: begin
            stall_left = 0;
          end
        endcase
      end
      if ($urandom_range(0, 199) == 0) begin
        stalls_on = !stalls_on;
      end
      if (stall_left > 0) begin
        stall_left--;
        records_ch.ready <= 1'b0;
      end else begin
        records_ch.ready <= 1'b1;
      end
    end
  end

  // Record checker and watchdog. Both channels are sampled at the rising
  // edge, before anything driven at that edge takes effect.
  always @(posedge clk) begin
    point_rec_t got;
    point_rec_t want;
    if (!rst) begin
      if (records_ch.valid && records_ch.ready) begin
        got = '{records_ch.coord_x, records_ch.coord_y, records_ch.coord_z,
                records_ch.color_red, records_ch.color_green, records_ch.color_blue};
        if (expected_points.size() == 0) begin
          flag_error($sformatf("record transaction with none expected: %0d %0d %0d %0d %0d %0d",
                               got.coord_x, got.coord_y, got.coord_z,
                               got.color_red, got.color_green, got.color_blue));
        end else begin
          want = expected_points.pop_front();
          check_field("coord_x", got.coord_x, want.coord_x);
          check_field("coord_y", got.coord_y, want.coord_y);
          check_field("coord_z", got.coord_z, want.coord_z);
          check_field("color_red", got.color_red, want.color_red);
          check_field("color_green", got.color_green, want.color_green);
          check_field("color_blue", got.color_blue, want.color_blue);
        end
      end
      // A correct run never goes long without a transaction on either side:
      // the worst case is a long input gap next to a long output stall.
      if ((chars_ch.valid && chars_ch.ready) || (records_ch.valid && records_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    bit         made;
    point_rec_t rec;
    int         sent;
    chars_ch.valid     <= 1'b0;
    chars_ch.char_byte <= 8'h00;
    error_count = 0;
    idle_cycles = 0;
    gaps_on     = 1'b1;
    clear_line_state();

    // Saturation: the first field is one past the maximum.
    row_text[0]    = "16777216 0 1 2 3 9\n";
    row_typed[0]   = 1'b1;
    row_has_rec[0] = 1'b1;
    row_rec[0]     = '{out_value_t'(VALUE_MAX), 24'd0, 24'd1, 24'd2, 24'd3, 24'd9};
    // Skipped bytes inside a number, a leading space that closes nothing,
    // and the largest value that fits without saturating.
    row_text[1]    = " 4\t5-8.5\r 16777215 7 8 0 1\n";
    row_typed[1]   = 1'b1;
    row_has_rec[1] = 1'b1;
    row_rec[1]     = '{24'd4585, out_value_t'(VALUE_MAX), 24'd7, 24'd8, 24'd0, 24'd1};
    // Seven fields: the line is dropped.
    row_text[2]    = "1 2 3 4 5 6 7\n";
    row_typed[2]   = 1'b1;
    row_has_rec[2] = 1'b0;
    // Top byte value, one field and a doubled trailing space: dropped.
    row_text[3]    = "\377 5  \n";
    row_typed[3]   = 1'b1;
    row_has_rec[3] = 1'b0;
    // Empty line.
    row_text[4]    = "\n";
    row_typed[4]   = 1'b1;
    row_has_rec[4] = 1'b0;
    // Trailing space before the newline; checked against the predictor.
    row_text[5]    = "5 4 3 2 1 0 \n";
    row_typed[5]   = 1'b0;
    row_has_rec[5] = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed lines. A typed row's expectation replaces the predicted one;
    // the predictor still walks every byte so that its state stays in step.
    for (int r = 0; r < N_ROWS; r++) begin
      for (int i = 0; i < row_text[r].len(); i++) begin
        push_char(row_text[r][i], made, rec);
        if (made && !row_typed[r]) begin
          expected_points = {expected_points, rec};
        end
      end
      if (row_typed[r] && row_has_rec[r]) begin
        expected_points = {expected_points, row_rec[r]};
      end
    end

    // Random lines until the byte budget is spent.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        gaps_on = !gaps_on;
      end
      compose_line();
      foreach (text_line[i]) begin
        push_char(text_line[i], made, rec);
        if (made) begin
          expected_points = {expected_points, rec};
        end
      end
      sent += text_line.size();
    end

    // A complete last line with no newline must never show up as a record.
    text_line.delete();
    for (int f = 0; f < FIELDS_PER_LINE; f++) begin
      add_char(8'(CHAR_ZERO + 8'($urandom_range(1, 9))));
      if (f < FIELDS_PER_LINE - 1) begin
        add_char(CHAR_SPACE);
      end
    end
    foreach (text_line[i]) begin
      push_char(text_line[i], made, rec);
      if (made) begin
        expected_points = {expected_points, rec};
      end
    end
    chars_ch.valid <= 1'b0;

    // Let the outstanding records drain, then keep the clock running for a
    // drain period so that the parser can show anything it should not produce.
    while (expected_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_points.size() != 0) begin
      flag_error($sformatf("%0d records never arrived", expected_points.size()));
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
